// File: design/kufps_pkg.sv
// Shared constants for the union-find pair-sum block.
// Fixed port widths, rank limits and the reset vertex count. Nothing else is required.
`default_nettype none

package kufps_pkg;

    // fixed port widths
    localparam int SRC_W       = 10;
    localparam int WEIGHT_IN_W = 32;
    localparam int CFG_W       = 11;
    localparam int SUM_W       = 64;

    // rank field of a forest entry
    localparam int RANK_W = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // vertex count after reset
    localparam logic [CFG_W-1:0] VC_RESET = 11'd1024;

endpackage : kufps_pkg

`default_nettype wire

// File: design/kruskal_union_find_pair_sum.sv
// Union-by-rank disjoint-set forest with a saturating weighted pair sum.
// One module; forest in a single synchronous memory. Depends on kufps_pkg.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+-----------------------------
//  edge in  | edge_src, edge_dst, edge_weight, last_edge | start && !busy
//  result   | merged, pair_sum, finished               | result_valid, one cycle
//  config   | cfg_data (vertex_count)                  | cfg_valid && cfg_ready
//
// After reset the forest memory is cleared one entry a cycle with busy high. A merging
// edge walks from each endpoint to its root, one parent hop per cycle on the single read
// port of the forest memory, writes the child and root entries while it multiplies, then
// combines and accumulates; an edge inside one set stops after the walks, a finished block
// or a rejected edge goes straight to the finish step. The result beat appears in the
// cycle after the last working cycle and cannot be stalled by the receiver.
`default_nettype none

module kruskal_union_find_pair_sum #(
    parameter int MAX_NODES   = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // edge beat
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [kufps_pkg::SRC_W-1:0]       edge_src,
    input  wire logic [kufps_pkg::SRC_W-1:0]       edge_dst,
    input  wire logic [kufps_pkg::WEIGHT_IN_W-1:0] edge_weight,
    input  wire logic                              last_edge,
    // result beat
    output logic                                   result_valid,
    output logic                                   merged,
    output logic [kufps_pkg::SUM_W-1:0]            pair_sum,
    output logic                                   finished,
    // vertex_count write
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kufps_pkg::CFG_W-1:0]       cfg_data
);
    import kufps_pkg::*;

    // derived widths
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int SIZE_W = $clog2(MAX_NODES + 1);
    localparam int VC_W   = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
    localparam int SP_W   = 2 * SIZE_W;
    localparam int HALF_W = (WEIGHT_BITS + 1) / 2;
    localparam int HIGH_W = WEIGHT_BITS - HALF_W;
    localparam int FULL_W = SP_W + WEIGHT_BITS;
    localparam int PROD_W = (FULL_W > SUM_W) ? FULL_W : SUM_W + 1;
    localparam int WX_W   = (WEIGHT_BITS > WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [RANK_W-1:0] rank;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_U,
        S_FIND_V,
        S_MUL_S,
        S_MUL_W,
        S_COMB,
        S_ACC,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [NODE_W-1:0]      clr_cnt_reg;
    logic [CFG_W-1:0]       vertex_count_reg;
    logic [VC_W-1:0]        edges_taken_reg;
    logic [SUM_W-1:0]       pair_total_reg;
    logic                   done_reg;
    logic                   result_valid_reg;
    logic                   merged_reg;

    // per-edge working registers (no reset)
    logic [NODE_W-1:0]      dst_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic                   last_reg;
    logic [NODE_W-1:0]      cur_reg;
    logic [NODE_W-1:0]      ru_reg;
    logic [NODE_W-1:0]      rv_reg;
    entry_t                 ent_u_reg;
    entry_t                 ent_v_reg;
    logic [SP_W-1:0]        sprod_reg;
    logic [SP_W+HALF_W-1:0] pp_lo_reg;
    logic [SP_W+HIGH_W-1:0] pp_hi_reg;
    logic [SUM_W-1:0]       prod_reg;

    // forest memory
    entry_t                 forest_mem [MAX_NODES];
    entry_t                 rd_q;
    logic                   mem_we;
    logic [NODE_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;
    logic [NODE_W-1:0]      mem_raddr;

    // effective vertex count and edge checks
    logic [VC_W-1:0]        vc_raw;
    logic [VC_W-1:0]        vc;
    logic [VC_W-1:0]        src_ext;
    logic [VC_W-1:0]        dst_ext;
    logic                   in_range;
    logic [WX_W-1:0]        weight_ext;

    // union decisions
    logic                   u_wins;
    logic [NODE_W-1:0]      root_idx;
    entry_t                 child_ent;
    entry_t                 root_ent;
    logic [RANK_W-1:0]      rank_next;

    // arithmetic
    logic [PROD_W-1:0]      full_prod;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       pair_total_next;
    logic                   done_next;

    logic                   accept;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // clamp the vertex count into 1..MAX_NODES
    assign vc_raw = VC_W'(vertex_count_reg);
    always_comb
    begin
        priority if (vc_raw == '0)
            vc = VC_W'(1);
        else if (vc_raw > VC_W'(MAX_NODES))
            vc = VC_W'(MAX_NODES);
        else
            vc = vc_raw;
    end

    assign src_ext    = VC_W'(edge_src);
    assign dst_ext    = VC_W'(edge_dst);
    assign in_range   = (src_ext < vc) && (dst_ext < vc);
    assign weight_ext = WX_W'(edge_weight);

    // root with the higher rank stays on top; ties keep the source root
    assign u_wins    = (ent_u_reg.rank >= ent_v_reg.rank);
    assign root_idx  = u_wins ? ru_reg : rv_reg;
    assign child_ent = u_wins ? ent_v_reg : ent_u_reg;
    assign root_ent  = u_wins ? ent_u_reg : ent_v_reg;
    assign rank_next = ((ent_u_reg.rank == ent_v_reg.rank) && (ent_u_reg.rank < RANK_MAX))
                       ? ent_u_reg.rank + RANK_W'(1) : root_ent.rank;

    // recombine the partial products, saturate, then accumulate
    assign full_prod = PROD_W'(pp_lo_reg) + (PROD_W'(pp_hi_reg) << HALF_W);
    assign sum_wide  = {1'b0, pair_total_reg} + {1'b0, prod_reg};
    assign pair_total_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    assign done_next = done_reg || last_reg || (edges_taken_reg >= vc - VC_W'(1));

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '{parent: clr_cnt_reg, rank: '0, size: SIZE_W'(1)};
        mem_raddr = rd_q.parent;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                mem_raddr = src_ext[NODE_W-1:0];
            end
            S_FIND_U:
            begin
                if (rd_q.parent == cur_reg)
                    mem_raddr = dst_reg;
            end
            S_MUL_S:
            begin
                mem_we    = 1'b1;
                mem_waddr = u_wins ? rv_reg : ru_reg;
                mem_wdata = '{parent: root_idx, rank: child_ent.rank, size: child_ent.size};
            end
            S_MUL_W:
            begin
                mem_we    = 1'b1;
                mem_waddr = root_idx;
                mem_wdata = '{parent: root_idx, rank: rank_next,
                              size: ent_u_reg.size + ent_v_reg.size};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // forest memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            forest_mem[mem_waddr] <= mem_wdata;
        rd_q <= forest_mem[mem_raddr];
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            vertex_count_reg <= VC_RESET;
            edges_taken_reg  <= '0;
            pair_total_reg   <= '0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            merged_reg       <= 1'b0;
        end
        else
        begin
            // result beat follows the finishing cycle
            result_valid_reg <= (state_reg == S_FINISH);
            if (cfg_valid && cfg_ready)
                vertex_count_reg <= cfg_data;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
                    if (clr_cnt_reg == NODE_W'(MAX_NODES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        merged_reg <= 1'b0;
                        if (done_reg || !in_range)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_FIND_U;
                    end
                end
                S_FIND_U:
                begin
                    if (rd_q.parent == cur_reg)
                        state_reg <= S_FIND_V;
                end
                S_FIND_V:
                begin
                    if (rd_q.parent == cur_reg)
                    begin
                        if (cur_reg == ru_reg)
                            state_reg <= S_FINISH;
                        else
                            state_reg <= S_MUL_S;
                    end
                end
                S_MUL_S:
                begin
                    state_reg <= S_MUL_W;
                end
                S_MUL_W:
                begin
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    pair_total_reg  <= pair_total_next;
                    edges_taken_reg <= edges_taken_reg + VC_W'(1);
                    merged_reg      <= 1'b1;
                    state_reg       <= S_FINISH;
                end
                S_FINISH:
                begin
                    done_reg  <= done_next;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // per-edge datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_reg    <= src_ext[NODE_W-1:0];
                    dst_reg    <= dst_ext[NODE_W-1:0];
                    weight_reg <= weight_ext[WEIGHT_BITS-1:0];
                    last_reg   <= last_edge;
                end
            end
            S_FIND_U:
            begin
                if (rd_q.parent == cur_reg)
                begin
                    ru_reg    <= cur_reg;
                    ent_u_reg <= rd_q;
                    cur_reg   <= dst_reg;
                end
                else
                    cur_reg <= rd_q.parent;
            end
            S_FIND_V:
            begin
                if (rd_q.parent == cur_reg)
                begin
                    rv_reg    <= cur_reg;
                    ent_v_reg <= rd_q;
                end
                else
                    cur_reg <= rd_q.parent;
            end
            S_MUL_S:
            begin
                sprod_reg <= SP_W'(ent_u_reg.size) * SP_W'(ent_v_reg.size);
            end
            S_MUL_W:
            begin
                pp_lo_reg <= (SP_W + HALF_W)'(sprod_reg)
                             * (SP_W + HALF_W)'(weight_reg[HALF_W-1:0]);
                pp_hi_reg <= (SP_W + HIGH_W)'(sprod_reg)
                             * (SP_W + HIGH_W)'(weight_reg[WEIGHT_BITS-1:HALF_W]);
            end
            S_COMB:
            begin
                prod_reg <= (|full_prod[PROD_W-1:SUM_W]) ? '1 : full_prod[SUM_W-1:0];
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    // outputs
    assign result_valid = result_valid_reg;
    assign merged       = merged_reg;
    assign pair_sum     = pair_total_reg;
    assign finished     = done_reg;

`ifndef SYNTHESIS
    // a result beat lasts one cycle
    a_beat_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beat longer than one cycle");

    // finished is sticky until reset
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(done_reg))
        else $error("finished fell without reset");

    // the running sum never drops
    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        pair_total_reg >= $past(pair_total_reg))
        else $error("pair sum decreased");

    // the union count moves only on the accumulate step
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (edges_taken_reg != $past(edges_taken_reg)) |-> $past(state_reg == S_ACC))
        else $error("edge count changed outside accumulate");

    // a finished forest is never written
    a_no_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !mem_we)
        else $error("forest written after finishing");
`endif

endmodule : kruskal_union_find_pair_sum

`default_nettype wire

// File: tb/sv/kufps_checker.sv
// Checker for the union-find pair-sum block: watches the edge, result and vertex_count
// channels, keeps its own disjoint-set forest and compares every result beat.
// Depends on kufps_pkg.
`default_nettype none

module kufps_checker #(
    parameter int MAX_NODES   = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic [kufps_pkg::SRC_W-1:0]       edge_src,
    input  wire logic [kufps_pkg::SRC_W-1:0]       edge_dst,
    input  wire logic [kufps_pkg::WEIGHT_IN_W-1:0] edge_weight,
    input  wire logic                              last_edge,
    input  wire logic                              result_valid,
    input  wire logic                              merged,
    input  wire logic [kufps_pkg::SUM_W-1:0]       pair_sum,
    input  wire logic                              finished,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [kufps_pkg::CFG_W-1:0]       cfg_data,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kufps_pkg::*;

    typedef struct packed {
        logic             merged;
        logic [SUM_W-1:0] sum;
        logic             finished;
    } edge_result_t;

    // shadow forest and running totals
    logic [SRC_W-1:0]  parent_tbl [MAX_NODES];
    logic [RANK_W-1:0] rank_tbl   [MAX_NODES];
    logic [CFG_W-1:0]  size_tbl   [MAX_NODES];
    logic [SUM_W-1:0]  sum_total;
    logic [SRC_W-1:0]  unions_done;
    logic              tree_done;
    logic [CFG_W-1:0]  vcount;

    edge_result_t result_due_q [$];

    // follow parent links up to the root, bounded at MAX_NODES steps
    function automatic int find_root(input int v);
        int steps;
        steps = 0;
        while (int'(parent_tbl[v]) != v && steps < MAX_NODES)
        begin
            v = int'(parent_tbl[v]) % MAX_NODES;
            steps++;
        end
        return v;
    endfunction

    // apply one edge to the shadow forest and return the result it should give
    function automatic edge_result_t take_edge(input logic [SRC_W-1:0] src,
                                               input logic [SRC_W-1:0] dst,
                                               input logic [WEIGHT_IN_W-1:0] weight,
                                               input logic last);
        int                 vc;
        int                 ru;
        int                 rv;
        logic [SUM_W-1:0]   wmask;
        logic [2*SUM_W-1:0] prod;
        logic [SUM_W-1:0]   term;
        logic [SUM_W:0]     acc;
        logic               hit;
        hit   = 1'b0;
        wmask = (64'd1 << WEIGHT_BITS) - 64'd1;
        vc    = int'(vcount);
        if (vc == 0)
            vc = 1;
        if (vc > MAX_NODES)
            vc = MAX_NODES;
        if (!tree_done)
        begin
            if (int'(src) < vc && int'(dst) < vc)
            begin
                ru = find_root(int'(src));
                rv = find_root(int'(dst));
                if (ru != rv)
                begin
                    prod = (2*SUM_W)'(size_tbl[ru]) * (2*SUM_W)'(size_tbl[rv])
                         * (2*SUM_W)'(SUM_W'(weight) & wmask);
                    term = (prod[2*SUM_W-1:SUM_W] != '0) ? '1 : prod[SUM_W-1:0];
                    acc  = {1'b0, sum_total} + {1'b0, term};
                    sum_total = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
                    unions_done = unions_done + 1'b1;
                    hit = 1'b1;
                    // union by rank, ties hang the dst root under the src root
                    if (rank_tbl[ru] >= rank_tbl[rv])
                    begin
                        if (rank_tbl[ru] == rank_tbl[rv] && rank_tbl[ru] < RANK_MAX)
                            rank_tbl[ru] = rank_tbl[ru] + 1'b1;
                        parent_tbl[rv] = SRC_W'(ru);
                        size_tbl[ru]   = size_tbl[ru] + size_tbl[rv];
                    end
                    else
                    begin
                        parent_tbl[ru] = SRC_W'(rv);
                        size_tbl[rv]   = size_tbl[rv] + size_tbl[ru];
                    end
                end
            end
            if (int'(unions_done) >= vc - 1 || last)
                tree_done = 1'b1;
        end
        return '{merged: hit, sum: sum_total, finished: tree_done};
    endfunction

    function automatic void report(input string what, input edge_result_t want,
                                   input edge_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%t %s: merged %0b/%0b pair_sum %0h/%0h finished %0b/%0b (exp/act)",
                     $realtime, what, want.merged, got.merged, want.sum, got.sum,
                     want.finished, got.finished);
    endfunction

    // sample all channels on the rising edge, same as the block
    always @(posedge clk or negedge rst_n)
    begin : watch
        edge_result_t want;
        edge_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                parent_tbl[i] = SRC_W'(i);
                rank_tbl[i]   = '0;
                size_tbl[i]   = CFG_W'(1);
            end
            sum_total   = '0;
            unions_done = '0;
            tree_done   = 1'b0;
            vcount      = VC_RESET;
            result_due_q.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            // result beat against the oldest expectation
            if (result_valid)
            begin
                got = '{merged: merged, sum: pair_sum, finished: finished};
                if (result_due_q.size() == 0)
                begin
                    want = 'x;
                    report("result beat with no edge outstanding", want, got);
                end
                else
                begin
                    want = result_due_q.pop_front();
                    if (got.merged !== want.merged || got.sum !== want.sum
                        || got.finished !== want.finished)
                        report("result mismatch", want, got);
                end
            end
            // accepted edge beat, queued at the tail
            if (start && !busy)
            begin
                want = take_edge(edge_src, edge_dst, edge_weight, last_edge);
                result_due_q.insert(result_due_q.size(), want);
            end
            // a register write counts from the next edge on
            if (cfg_valid && cfg_ready)
                vcount = cfg_data;
            pending = result_due_q.size();
        end
    end

endmodule : kufps_checker

`default_nettype wire

// File: tb/sv/kruskal_union_find_pair_sum_tb.sv
// Testbench top for kruskal_union_find_pair_sum: clock, reset, edge and vertex_count
// stimulus, and the verdict. Depends on kufps_pkg, the block and kufps_checker.
`default_nettype none

module kruskal_union_find_pair_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kufps_pkg::*;

    localparam int          MAX_NODES    = 1024;
    localparam int          WEIGHT_BITS  = 32;
    localparam int          HALF_PERIOD  = 4;
    localparam int          PHASE_ITEMS  = 200;
    localparam int          DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   start       = 1'b0;
    logic [SRC_W-1:0]       edge_src    = '0;
    logic [SRC_W-1:0]       edge_dst    = '0;
    logic [WEIGHT_IN_W-1:0] edge_weight = '0;
    logic                   last_edge   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_W-1:0]       cfg_data    = '0;
    logic                   busy;
    logic                   result_valid;
    logic                   merged;
    logic [SUM_W-1:0]       pair_sum;
    logic                   finished;
    logic                   cfg_ready;
    int                     fail_count;
    int                     pending;

    // stimulus state
    int                     vc_limit;
    logic [WEIGHT_IN_W-1:0] weight_run;
    bit                     calm;
    logic [SRC_W-1:0]       recent_vtx [16];
    int unsigned            cycle_count = 0;

    kruskal_union_find_pair_sum #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .edge_src     (edge_src),
        .edge_dst     (edge_dst),
        .edge_weight  (edge_weight),
        .last_edge    (last_edge),
        .result_valid (result_valid),
        .merged       (merged),
        .pair_sum     (pair_sum),
        .finished     (finished),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    kufps_checker #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .edge_src     (edge_src),
        .edge_dst     (edge_dst),
        .edge_weight  (edge_weight),
        .last_edge    (last_edge),
        .result_valid (result_valid),
        .merged       (merged),
        .pair_sum     (pair_sum),
        .finished     (finished),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one edge beat; entered and left just after a falling edge
    task automatic send_edge(input logic [SRC_W-1:0] src, input logic [SRC_W-1:0] dst,
                             input logic [WEIGHT_IN_W-1:0] weight, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        edge_src    <= src;
        edge_dst    <= dst;
        edge_weight <= weight;
        last_edge   <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // vertex_count write, only once every result is back and the block is idle
    task automatic write_vertex_count(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (value == '0)
            vc_limit = 1;
        else if (int'(value) > MAX_NODES)
            vc_limit = MAX_NODES;
        else
            vc_limit = int'(value);
    endtask

    // mostly in-range edges with falling weights; some revisits, loops and noise
    task automatic random_edge(input logic last);
        int                     pick;
        int unsigned            dec;
        logic [SRC_W-1:0]       src;
        logic [SRC_W-1:0]       dst;
        logic [WEIGHT_IN_W-1:0] weight;
        pick = $urandom_range(0, 99);
        src  = SRC_W'($urandom_range(0, vc_limit - 1));
        dst  = SRC_W'($urandom_range(0, vc_limit - 1));
        if (pick < 20)
        begin
            // recently touched vertices: same-set hits and longer root walks
            src = recent_vtx[$urandom_range(0, 15)];
            dst = recent_vtx[$urandom_range(0, 15)];
        end
        else if (pick < 28)
            dst = src;
        else if (pick < 38)
        begin
            src = SRC_W'($urandom);
            dst = SRC_W'($urandom);
        end
        recent_vtx[$urandom_range(0, 15)] = src;
        recent_vtx[$urandom_range(0, 15)] = dst;
        if (pick >= 95)
            weight = $urandom;
        else
        begin
            dec = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32'h0200_0000);
            weight_run = (dec > weight_run) ? '0 : weight_run - dec;
            weight = weight_run;
        end
        send_edge(src, dst, weight, last);
    endtask

    initial
    begin : stimulus
        int                 ending;
        logic [CFG_W-1:0]   phase_vc [4];
        logic               last;
        vc_limit = MAX_NODES;
        calm     = 1'b0;
        for (int i = 0; i < 16; i++)
            recent_vtx[i] = SRC_W'(i);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count above capacity, clamped
        write_vertex_count(11'h7FF);

        // directed: extremes, same set, self loop, rank cases
        send_edge(10'd0, 10'd1023, 32'hFFFF_FFFF, 1'b0);
        send_edge(10'd1023, 10'd0, 32'hFFFF_FFFF, 1'b0);
        send_edge(10'd5, 10'd5, 32'hFFFF_FFFF, 1'b0);
        send_edge(10'd2, 10'd3, 32'hFFFF_0000, 1'b0);
        send_edge(10'd0, 10'd2, 32'hF000_0000, 1'b0);
        send_edge(10'd4, 10'd1023, 32'hC000_0000, 1'b0);
        // rank-3 tree on 100..107 for a deep walk
        send_edge(10'd100, 10'd101, 32'h8000_0000, 1'b0);
        send_edge(10'd102, 10'd103, 32'h7000_0000, 1'b0);
        send_edge(10'd104, 10'd105, 32'h6000_0000, 1'b0);
        send_edge(10'd106, 10'd107, 32'h5000_0000, 1'b0);
        send_edge(10'd100, 10'd102, 32'h4000_0000, 1'b0);
        send_edge(10'd104, 10'd106, 32'h3000_0000, 1'b0);
        send_edge(10'd100, 10'd104, 32'h2000_0000, 1'b0);
        send_edge(10'd107, 10'd101, 32'h2000_0000, 1'b0);
        send_edge(10'd107, 10'd3, 32'h1000_0000, 1'b0);
        // zero weight, then an out-of-order weight
        send_edge(10'd6, 10'd7, 32'h0000_0000, 1'b0);
        send_edge(10'd8, 10'd9, 32'h1234_5678, 1'b0);

        // endpoints outside a reduced count are ignored
        write_vertex_count(11'd512);
        send_edge(10'd600, 10'd1, 32'h0000_0000, 1'b0);
        send_edge(10'd1, 10'd1023, 32'h0000_0000, 1'b0);
        send_edge(10'd511, 10'd510, 32'h0000_0000, 1'b0);

        // random phases, each with its own count and a fresh falling weight run
        phase_vc[0] = CFG_W'($urandom_range(513, 1023));
        phase_vc[1] = CFG_W'($urandom_range(1024, 2047));
        phase_vc[2] = 11'd1024;
        phase_vc[3] = 11'h7FF;
        for (int p = 0; p < 4; p++)
        begin
            write_vertex_count(phase_vc[p]);
            weight_run = 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                random_edge(1'b0);
            end
        end

        // finish by one vertex, by the count, or by the last-edge flag
        calm   = 1'b0;
        ending = $urandom_range(0, 3);
        case (ending)
            0: write_vertex_count(11'd0);
            1: write_vertex_count(11'd1);
            2: write_vertex_count(11'd2);
            default: ;
        endcase
        for (int k = 0; k < 6; k++)
        begin
            last = (k == 5) || (k == 0 && ending == 3) || ($urandom_range(0, 3) == 0);
            random_edge(last);
        end
        start <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : kruskal_union_find_pair_sum_tb

`default_nettype wire
